[design/permutation_order_crossover_assert.svh]
// Assertion macros for the order crossover block.
// Clocked on clk, quiet while rst is high; no other dependencies.
`ifndef PERMUTATION_ORDER_CROSSOVER_ASSERT_SVH
`define PERMUTATION_ORDER_CROSSOVER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define POC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define POC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/poc_pkg.sv]
// Shared constants for the order crossover block.
// No dependencies.
`timescale 1ns / 1ps

package poc_pkg;

  localparam int CITY_W     = 8;
  localparam int NUM_W      = 9;
  localparam int MAX_CITIES = 256;
  localparam int SEEN_DEPTH = 1 << CITY_W;

  // Run tag held in the seen memory; zero is reserved for cleared entries
  localparam int              EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  // Request kinds
  localparam logic KIND_P1 = 1'b0;
  localparam logic KIND_P2 = 1'b1;

  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(256);
  localparam logic [NUM_W-1:0] NUM_MIN   = NUM_W'(2);
  localparam logic [NUM_W-1:0] NUM_MAX   = NUM_W'(MAX_CITIES);
  localparam logic [NUM_W-1:0] EMIT_SAT  = {NUM_W{1'b1}};

endpackage

[design/poc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module poc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/permutation_order_crossover.sv]
// Top level of the one-point order crossover block.
// Depends on poc_pkg, poc_ram and permutation_order_crossover_assert.svh.
`timescale 1ns / 1ps

// Builds a child permutation from a stream of parent cities. Parent-one
// requests (tuser 0) below the cut point pass to the child; parent-two
// requests (tuser 1) pass when their city has not been seen in this run.
// The final child city carries tlast, and the run state clears itself after
// the last parent-two request. One request is taken every clock cycle
// unless a sweep runs or is due or the output stalls: the city is looked
// up in the seen memory on acceptance; the decision, memory write-back and
// counters complete in stage one, with a bypass for back-to-back requests
// on the same city. Runs are told apart by an 8-bit tag in the seen memory,
// so a new run needs no clearing; a sweep clearing all 256 entries runs
// after reset and after every 255th completed run, blocking requests. An
// output register lets the next request in while a result waits.
module permutation_order_crossover
  import poc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration: num_cities
  input  logic              cfg_we,
  input  logic [NUM_W-1:0]  cfg_data,
  // parent cities in
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // city [7:0], cut_point [15:8]
  input  logic              s_tuser,   // kind
  // child cities out
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CITY_W-1:0] m_tdata,   // child_city [7:0]
  output logic              m_tlast    // last_of_child
);

  // configuration register
  logic [NUM_W-1:0] num_cities;

  // stage one: request waiting for its memory data
  logic              s1_valid;
  logic              s1_kind;
  logic [CITY_W-1:0] s1_city;
  logic [CITY_W-1:0] s1_cut;

  // run state
  logic [NUM_W-1:0]   p1_pos;
  logic [NUM_W-1:0]   p2_pos;
  logic [NUM_W-1:0]   emitted;
  logic [EPOCH_W-1:0] epoch;

  // bypass of the last write-back
  logic              fwd_valid;
  logic [CITY_W-1:0] fwd_city;

  // clearing sweep
  logic              sweeping;
  logic [CITY_W-1:0] sweep_addr;

  // memory ports
  logic               ram_we;
  logic [CITY_W-1:0]  ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [EPOCH_W-1:0] ram_rdata;

  // decision logic
  logic [NUM_W-1:0] n_eff;
  logic             seen;
  logic             p1_emit;
  logic             final_two;
  logic             emit;
  logic [NUM_W-1:0] emitted_inc;
  logic             last;
  logic             out_free;
  logic             s1_go;
  logic             wrap_pending;
  logic             accept;

  // effective city count, clamped to the legal range
  always_comb begin
    if (num_cities < NUM_MIN) begin
      n_eff = NUM_MIN;
    end else if (num_cities > NUM_MAX) begin
      n_eff = NUM_MAX;
    end else begin
      n_eff = num_cities;
    end
  end

  // emit decision for the request in stage one
  always_comb begin
    seen        = (ram_rdata == epoch) || (fwd_valid && (fwd_city == s1_city));
    p1_emit     = (p1_pos < n_eff) && (p1_pos < {1'b0, s1_cut});
    final_two   = (s1_kind == KIND_P2) &&
                  (({1'b0, p2_pos} + (NUM_W+1)'(1)) >= {1'b0, n_eff});
    emit        = (s1_kind == KIND_P2) ? !seen : p1_emit;
    emitted_inc = (emitted != EMIT_SAT) ? emitted + NUM_W'(1) : emitted;
    last        = (emitted_inc == n_eff) || final_two;
  end

  // handshake
  assign out_free     = !m_tvalid || m_tready;
  assign s1_go        = s1_valid && (out_free || !emit);
  assign wrap_pending = s1_valid && final_two && (epoch == EPOCH_LAST);
  assign s_tready     = !sweeping && !wrap_pending && (!s1_valid || s1_go);
  assign accept       = s_tvalid && s_tready;

  // write-back or clearing sweep share the write port
  always_comb begin
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_go && emit;
      ram_waddr = s1_city;
      ram_wdata = epoch;
    end
  end

  poc_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (SEEN_DEPTH)
  ) u_seen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (s_tdata[CITY_W-1:0]),
    .rdata (ram_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cities <= NUM_RESET;
    end else if (cfg_we) begin
      num_cities <= cfg_data;
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= s_tuser;
      s1_city <= s_tdata[CITY_W-1:0];
      s1_cut  <= s_tdata[2*CITY_W-1:CITY_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      m_tdata <= s1_city;
      m_tlast <= last;
    end
  end

  // run counters
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_pos  <= '0;
      p2_pos  <= '0;
      emitted <= '0;
    end else if (s1_go) begin
      if (final_two) begin
        p1_pos  <= '0;
        p2_pos  <= '0;
        emitted <= '0;
      end else begin
        if (s1_kind == KIND_P2) begin
          p2_pos <= p2_pos + NUM_W'(1);
        end else if (p1_pos < n_eff) begin
          p1_pos <= p1_pos + NUM_W'(1);
        end
        if (emit) begin
          emitted <= emitted_inc;
        end
      end
    end
  end

  // bypass of the write-back for the request read alongside it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_go) begin
      fwd_valid <= emit && !final_two;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      fwd_city <= s1_city;
    end
  end

  // run tag and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= EPOCH_FIRST;
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + CITY_W'(1);
      if (sweep_addr == {CITY_W{1'b1}}) begin
        sweeping <= 1'b0;
      end
    end else if (s1_go && final_two) begin
      if (epoch == EPOCH_LAST) begin
        epoch      <= EPOCH_FIRST;
        sweeping   <= 1'b1;
        sweep_addr <= '0;
      end else begin
        epoch <= epoch + EPOCH_W'(1);
      end
    end
  end

  // checks
`include "permutation_order_crossover_assert.svh"

  `POC_ASSERT_SAME(a_no_accept_in_sweep, sweeping, !accept && !s1_valid, "request during sweep")
  `POC_ASSERT_SAME(a_sweep_owns_port, sweeping, !(s1_go && emit), "write-back during sweep")
  `POC_ASSERT_NEXT(a_run_cleared, s1_go && final_two, (p1_pos == '0) && (p2_pos == '0) && (emitted == '0) && !fwd_valid, "run state not cleared")
  `POC_ASSERT_NEXT(a_epoch_nonzero, 1'b1, epoch != '0, "run tag hit reserved value")

endmodule
